// File: src/rcfp_pkg.sv
// ----------------------------------------------------------------------------
// rcfp_pkg
// Shared types, constants and the CRC-8 byte step for the RC channel
// frame packer.
// ----------------------------------------------------------------------------
package rcfp_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 16;
  localparam int unsigned CHANNEL_BITS_DEF = 11;
  localparam int unsigned CHANNEL_VALUE_W  = 11;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam int unsigned CFG_INDEX_W      = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLY   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEST_ADDR  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LEN  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_TYPE = 2'd3;

  localparam logic [BYTE_W-1:0] CRC_POLY_RST   = 8'hD5;
  localparam logic [BYTE_W-1:0] DEST_ADDR_RST  = 8'hC8;
  localparam logic [BYTE_W-1:0] FRAME_LEN_RST  = 8'd24;
  localparam logic [BYTE_W-1:0] FRAME_TYPE_RST = 8'd22;
  localparam logic [BYTE_W-1:0] CRC_INIT       = 8'h00;

  typedef struct packed {
    logic [BYTE_W-1:0] crc_poly;
    logic [BYTE_W-1:0] dest_addr;
    logic [BYTE_W-1:0] frame_len;
    logic [BYTE_W-1:0] frame_type;
  } rcfp_cfg_t;

  // One queued channel, classified by the front end
  typedef struct packed {
    logic [CHANNEL_VALUE_W-1:0] value;
    logic                       last;
  } rcfp_item_t;

  // MSB-first CRC-8 over one byte
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data,
                                                  input logic [BYTE_W-1:0] poly);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: src/rcfp_front.sv
// ----------------------------------------------------------------------------
// rcfp_front
// Accepts channel beats, counts channels within a frame and tags the
// closing channel before handing items to the queue.
// ----------------------------------------------------------------------------
module rcfp_front #(
  parameter int unsigned NUM_CHANNELS = rcfp_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [rcfp_pkg::CHANNEL_VALUE_W-1:0]  in_channel_value,
  input  logic                                  q_full,
  output logic                                  q_push,
  output rcfp_pkg::rcfp_item_t                  q_item
);
  import rcfp_pkg::*;

  localparam int unsigned CNT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_CHANNELS - 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             is_last;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign is_last  = (count_r == LAST_CNT);

  assign q_item.value = in_channel_value;
  assign q_item.last  = is_last;

  always_comb begin
    count_nxt = count_r;
    if (q_push) begin
      count_nxt = is_last ? '0 : count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// File: src/rcfp_queue.sv
// ----------------------------------------------------------------------------
// rcfp_queue
// Small FIFO of classified channel items between front and back end.
// ----------------------------------------------------------------------------
module rcfp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  rcfp_pkg::rcfp_item_t  push_item,
  output logic                  full,
  output logic                  head_valid,
  output rcfp_pkg::rcfp_item_t  head_item,
  input  logic                  pop
);
  import rcfp_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  rcfp_item_t       entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign full       = (fill_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// File: src/rcfp_back.sv
// ----------------------------------------------------------------------------
// rcfp_back
// Emits header bytes, packs channel bits LSB first into payload bytes,
// pads the tail and closes each frame with the CRC-8 byte.
// ----------------------------------------------------------------------------
module rcfp_back #(
  parameter int unsigned CHANNEL_BITS = rcfp_pkg::CHANNEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rcfp_pkg::rcfp_cfg_t          cfg,
  input  logic                         q_valid,
  input  rcfp_pkg::rcfp_item_t         q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rcfp_pkg::BYTE_W-1:0]  out_frame_byte,
  output logic                         out_last_byte
);
  import rcfp_pkg::*;

  localparam int unsigned VAL_W = (CHANNEL_BITS < CHANNEL_VALUE_W) ? CHANNEL_BITS
                                                                  : CHANNEL_VALUE_W;
  // worst case: seven leftover bits plus one whole channel
  localparam int unsigned ACC_W = CHANNEL_BITS + BYTE_W - 1;
  localparam int unsigned NB_W  = $clog2(ACC_W + 1);
  localparam logic [NB_W-1:0] NB_BYTE = NB_W'(BYTE_W);
  localparam logic [NB_W-1:0] NB_CHAN = NB_W'(CHANNEL_BITS);

  typedef enum logic [3:0] {
    ST_WAIT = 4'b0001,
    ST_LEN  = 4'b0010,
    ST_TYPE = 4'b0100,
    ST_DATA = 4'b1000
  } state_t;

  state_t            st_r, st_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt, acc_shift;
  logic [NB_W-1:0]   nb_r, nb_nxt, rem;
  logic [BYTE_W-1:0] crc_r, crc_nxt;
  logic              last_in_r, last_in_nxt;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  logic              can_emit;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last;

  assign can_emit       = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

  always_comb begin
    st_nxt      = st_r;
    crc_nxt     = crc_r;
    last_in_nxt = last_in_r;
    emit        = 1'b0;
    emit_byte   = '0;
    emit_last   = 1'b0;
    rem         = nb_r;
    q_pop       = 1'b0;
    acc_shift   = acc_r;
    acc_nxt     = acc_r;
    nb_nxt      = nb_r;

    case (st_r)
      ST_WAIT: begin
        if (q_valid && can_emit) begin
          emit      = 1'b1;
          emit_byte = cfg.dest_addr;
          st_nxt    = ST_LEN;
        end
      end
      ST_LEN: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_byte = cfg.frame_len;
          st_nxt    = ST_TYPE;
        end
      end
      ST_TYPE: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_byte = cfg.frame_type;
          crc_nxt   = crc8_byte(CRC_INIT, cfg.frame_type, cfg.crc_poly);
          acc_nxt   = '0;
          nb_nxt    = '0;
          st_nxt    = ST_DATA;
        end
      end
      ST_DATA: begin
        if (nb_r >= NB_BYTE) begin
          if (can_emit) begin
            emit      = 1'b1;
            emit_byte = acc_r[BYTE_W-1:0];
            crc_nxt   = crc8_byte(crc_r, acc_r[BYTE_W-1:0], cfg.crc_poly);
            rem       = nb_r - NB_BYTE;
          end
        end else if (last_in_r && nb_r != '0) begin
          // partial tail byte, high bits already zero
          if (can_emit) begin
            emit      = 1'b1;
            emit_byte = acc_r[BYTE_W-1:0];
            crc_nxt   = crc8_byte(crc_r, acc_r[BYTE_W-1:0], cfg.crc_poly);
            rem       = '0;
          end
        end else if (last_in_r) begin
          if (can_emit) begin
            emit        = 1'b1;
            emit_byte   = crc_r;
            emit_last   = 1'b1;
            crc_nxt     = CRC_INIT;
            last_in_nxt = 1'b0;
            rem         = '0;
            st_nxt      = ST_WAIT;
          end
        end

        acc_shift = emit ? (acc_r >> BYTE_W) : acc_r;
        acc_nxt   = acc_shift;
        nb_nxt    = rem;
        // merge the next channel once fewer than a byte of bits remain
        if (!last_in_r && q_valid && rem < NB_BYTE) begin
          q_pop       = 1'b1;
          acc_nxt     = acc_shift | (ACC_W'(q_item.value[VAL_W-1:0]) << rem);
          nb_nxt      = rem + NB_CHAN;
          last_in_nxt = q_item.last;
        end
      end
      default: begin
        st_nxt = ST_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_WAIT;
      acc_r       <= '0;
      nb_r        <= '0;
      crc_r       <= CRC_INIT;
      last_in_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      acc_r     <= acc_nxt;
      nb_r      <= nb_nxt;
      crc_r     <= crc_nxt;
      last_in_r <= last_in_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

endmodule

// File: src/rc_channel_frame_packer.sv
// ----------------------------------------------------------------------------
// rc_channel_frame_packer
// Packs 11-bit RC channel values into a byte stream: address, length and
// type header, LSB-first packed payload, zero-padded tail, CRC-8 trailer.
//
//   channel  dir  signals                                     width
//   in       in   in_valid / in_stall / in_channel_value      11
//   out      out  out_valid / out_stall / out_frame_byte,
//                 out_last_byte                               8 + 1
//   cfg      in   cfg_we / cfg_index / cfg_wdata              2 / 8
//
// One frame byte leaves per cycle at most, set by the single-byte output
// register of the back end; with the defaults a frame carries 26 bytes for
// 16 channels, header and CRC included.
// A four-entry queue lets input beats keep arriving while the output stalls, until it fills.
// Reset is synchronous; registers return to their published defaults.
// ----------------------------------------------------------------------------
module rc_channel_frame_packer #(
  parameter int unsigned NUM_CHANNELS = rcfp_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned CHANNEL_BITS = rcfp_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [rcfp_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [rcfp_pkg::BYTE_W-1:0]           cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [rcfp_pkg::CHANNEL_VALUE_W-1:0]  in_channel_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [rcfp_pkg::BYTE_W-1:0]           out_frame_byte,
  output logic                                  out_last_byte
);
  import rcfp_pkg::*;

  rcfp_cfg_t  cfg_r, cfg_nxt;
  logic       q_push, q_full, q_valid, q_pop;
  rcfp_item_t q_in_item, q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_CRC_POLY:   cfg_nxt.crc_poly   = cfg_wdata;
        REG_DEST_ADDR:  cfg_nxt.dest_addr  = cfg_wdata;
        REG_FRAME_LEN:  cfg_nxt.frame_len  = cfg_wdata;
        REG_FRAME_TYPE: cfg_nxt.frame_type = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_poly   <= CRC_POLY_RST;
      cfg_r.dest_addr  <= DEST_ADDR_RST;
      cfg_r.frame_len  <= FRAME_LEN_RST;
      cfg_r.frame_type <= FRAME_TYPE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rcfp_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_channel_value (in_channel_value),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (q_in_item)
  );

  rcfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in_item),
    .full       (q_full),
    .head_valid (q_valid),
    .head_item  (q_head),
    .pop        (q_pop)
  );

  rcfp_back #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_item         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule
